// File: src/meiyan_string_hash_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Meiyan string hash block
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef MEIYAN_STRING_HASH_DEFINES_SVH
`define MEIYAN_STRING_HASH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and held off during rst.
`define MSH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");
// Next-cycle implication, clocked on clk and held off during rst.
`define MSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");
`else
`define MSH_ASSERT_IMPLY(label, ante, cons)
`define MSH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/msh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants of the Meiyan string hash block.
// ----------------------------------------------------------------------------
package msh_pkg;

  // Hash constants.
  localparam logic [31:0] MY_SEED  = 32'h811c_9dc5;
  localparam logic [31:0] MY_PRIME = 32'h000a_d3e7;

  // Shift amounts of the block mix and of the finish.
  localparam int ROT_LEFT   = 5;
  localparam int ROT_RIGHT  = 27;
  localparam int FIN_SHIFT  = 16;

  // Field widths.
  localparam int CHUNK_W = 64;
  localparam int COUNT_W = 4;
  localparam int HASH_W  = 32;

  // Bytes in one full chunk.
  localparam logic [COUNT_W-1:0] FULL_BYTES = 4'd8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // Kind of one mix step.
  typedef enum logic [1:0] {
    KIND_BLOCK,
    KIND_HALF,
    KIND_BYTE
  } kind_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic  load;
    logic  step;
    kind_t kind;
    logic  finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: src/meiyan_string_hash.sv
`timescale 1ns / 1ps
// Each accepted chunk gets all of its mix steps before the next chunk is accepted. A
// chunk that is not last takes one block step; a last chunk takes one block step for
// eight bytes, else one step per 16-bit half plus one for an odd byte (0 to 4 steps),
// then the finish, which waits while the output is stalled. The single constant
// multiplier does one mix step per cycle. Synchronous reset loads the seed and empties the output.
// ----------------------------------------------------------------------------
// meiyan_string_hash
// Meiyan 32-bit hash of a key delivered as little-endian 8-byte chunks.
// ----------------------------------------------------------------------------
`include "meiyan_string_hash_defines.svh"

module meiyan_string_hash
  import msh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [HASH_W-1:0]  hash_value
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  msh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_count (byte_count),
    .last       (last),
    .status     (status),
    .cmd        (cmd)
  );

  // Hash datapath.
  msh_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .chunk      (chunk),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

  // A finished hash never overwrites a result that is still waiting.
  `MSH_ASSERT_IMPLY(a_no_overwrite, cmd.finish, !out_valid || !out_stall)
  // A finish always presents a result in the next cycle.
  `MSH_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid)
  // Once an item is taken, the input holds off while it is worked on.
  `MSH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

// File: src/msh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_ctrl
// Sequencer that walks one chunk through its mix steps and the finish.
// ----------------------------------------------------------------------------
module msh_ctrl
  import msh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               last,
  input  status_t            status,
  output cmd_t               cmd
);

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic               last_r;
  logic               last_r_next;

  logic               accept;
  logic [COUNT_W-1:0] start_count;
  kind_t              step_kind;
  logic [COUNT_W-1:0] step_dec;
  logic [COUNT_W-1:0] rem_after;

  assign accept = (state == ST_IDLE) && in_valid;

  // Counts above eight act as a full chunk; chunks before the last are always full.
  always_comb begin
    if (!last || byte_count >= FULL_BYTES) begin
      start_count = FULL_BYTES;
    end else begin
      start_count = byte_count;
    end
  end

  // A full block first, then halves, then one trailing byte.
  always_comb begin
    if (rem >= FULL_BYTES) begin
      step_kind = KIND_BLOCK;
      step_dec  = FULL_BYTES;
    end else if (rem >= 4'd2) begin
      step_kind = KIND_HALF;
      step_dec  = 4'd2;
    end else begin
      step_kind = KIND_BYTE;
      step_dec  = 4'd1;
    end
    rem_after = rem - step_dec;
  end

  // Next state and step counter.
  always_comb begin
    state_next  = state;
    rem_next    = rem;
    last_r_next = last_r;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rem_next    = start_count;
          last_r_next = last;
          if (start_count == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rem_next = rem_after;
        if (rem_after == '0) begin
          state_next = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake.
  always_comb begin
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.kind   = step_kind;
    cmd.finish = 1'b0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rem    <= '0;
      last_r <= 1'b0;
    end else begin
      state  <= state_next;
      rem    <= rem_next;
      last_r <= last_r_next;
    end
  end

endmodule

// File: src/msh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_datapath
// Running hash, chunk shifter, one constant multiplier and the result register.
// ----------------------------------------------------------------------------
module msh_datapath
  import msh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [CHUNK_W-1:0] chunk,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [HASH_W-1:0]  hash_value
);

  logic [HASH_W-1:0]  h;
  logic [CHUNK_W-1:0] chunk_r;

  logic [HASH_W-1:0]  lo;
  logic [HASH_W-1:0]  hi;
  logic [HASH_W-1:0]  rot;
  logic [HASH_W-1:0]  operand;
  logic [HASH_W-1:0]  mix_in;
  logic [HASH_W-1:0]  mix_out;
  logic [HASH_W-1:0]  fin_value;

  assign status.out_free = !out_valid || !out_stall;

  // Rotate with an arithmetic right part.
  assign lo  = chunk_r[HASH_W-1:0];
  assign hi  = chunk_r[CHUNK_W-1:HASH_W];
  assign rot = (lo << ROT_LEFT) | HASH_W'($signed(lo) >>> ROT_RIGHT);

  // Operand of one step; halves and bytes are sign-extended.
  always_comb begin
    case (cmd.kind)
      KIND_BLOCK: operand = rot ^ hi;
      KIND_HALF:  operand = {{16{chunk_r[15]}}, chunk_r[15:0]};
      KIND_BYTE:  operand = {{24{chunk_r[7]}}, chunk_r[7:0]};
      default:    operand = rot ^ hi;
    endcase
  end

  // One multiply by the constant per step, modulo 2^32.
  assign mix_in    = h ^ operand;
  assign mix_out   = mix_in * MY_PRIME;
  assign fin_value = h ^ HASH_W'($signed(h) >>> FIN_SHIFT);

  // Running hash.
  always_ff @(posedge clk) begin
    if (rst) begin
      h <= MY_SEED;
    end else if (cmd.finish) begin
      h <= MY_SEED;
    end else if (cmd.step) begin
      h <= mix_out;
    end
  end

  // Chunk register; each half step moves the next half down.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chunk_r <= chunk;
    end else if (cmd.step && cmd.kind == KIND_HALF) begin
      chunk_r <= chunk_r >> 16;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hash_value <= fin_value;
    end
  end

endmodule
